/* sv/bclm_pkg.sv */
// package for the block cache: sizes, result kinds and register indexes
package bclm_pkg;

    localparam int CAPACITY_DEF   = 64;
    localparam int MAX_BLOCKS_DEF = 16;

    localparam int KIND_W    = 3;
    localparam int CFG_IDX_W = 2;

    localparam logic [KIND_W-1:0] KIND_READ_HIT    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_DEMOTE_HIT  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_DEMOTE_MISS = 3'd2;
    localparam logic [KIND_W-1:0] KIND_READ_MISS   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_EVICT_DEM   = 3'd4;

    localparam logic ACT_READ   = 1'b0;
    localparam logic ACT_DEMOTE = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_EJECT_POLICY    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEMOTE_ON_EVICT = 2'd1;

    typedef struct packed {
        logic [31:0] obj;
        logic [31:0] blk;
    } t_entry;

endpackage

/* sv/block_cache_lru_mru_demote.sv */
// fully associative block cache with one ejection order, lru or mru insertion
// entries sit in a memory sorted by ejection rank (address 0 = head) with a fill count
// per block: a lookup scan from the head, a removal shift down to close the gap,
// then an insertion at the tail, or at the head after a shift up, one port pair
// a request keeps busy high until all of its blocks are done
// one-cycle result strobes, never stalled; reset empties the cache and clears the config registers
module block_cache_lru_mru_demote #(
    parameter int CAPACITY   = bclm_pkg::CAPACITY_DEF,
    parameter int MAX_BLOCKS = bclm_pkg::MAX_BLOCKS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic                           i_action,
    input  logic [7:0]                     i_origin,
    input  logic [31:0]                    i_object_id,
    input  logic [31:0]                    i_start_block,
    input  logic [4:0]                     i_block_count,
    output logic                           o_result_valid,
    output logic [bclm_pkg::KIND_W-1:0]    o_kind,
    output logic [31:0]                    o_out_object,
    output logic [31:0]                    o_out_block,
    output logic [7:0]                     o_out_origin,
    output logic                           o_last,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [bclm_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic                           i_cfg_data
);
    import bclm_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int OW = $clog2(CAPACITY + 1);
    localparam int CW = $clog2(MAX_BLOCKS + 1);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_LOOK  = 7'b0000010,
        S_SCAN  = 7'b0000100,
        S_SHDN  = 7'b0001000,
        S_INS   = 7'b0010000,
        S_SHUP  = 7'b0100000,
        S_HEADW = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    t_entry r_mem [CAPACITY];
    t_entry r_rd_data;
    t_entry r_head;
    t_entry w_key;
    t_entry w_wd;
    logic [AW-1:0] w_rd_addr, w_wa;
    logic          w_we;

    logic [AW-1:0] r_ptr, n_ptr;
    logic [OW-1:0] r_occ, n_occ;
    logic [CW-1:0] r_left, n_left;
    logic [31:0]   r_blk, n_blk;
    logic          r_hit, n_hit;
    logic          r_act;
    logic [7:0]    r_org;
    logic [31:0]   r_obj;
    logic          r_policy, r_demote;

    logic              r_out_valid, n_out_valid;
    logic [KIND_W-1:0] r_out_kind, n_out_kind;
    logic [31:0]       r_out_obj, n_out_obj;
    logic [31:0]       r_out_blk, n_out_blk;
    logic              r_out_last, n_out_last;
    logic [7:0]        r_out_org;

    logic [CW-1:0] w_cnt_sat;
    logic [OW:0]   w_ptr_p1, w_ptr_p2, w_occ_x;
    logic          w_at_head;
    logic          w_adv;

    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;

    assign w_cnt_sat = (int'(i_block_count) > MAX_BLOCKS) ? CW'(MAX_BLOCKS)
                                                           : CW'(i_block_count);
    assign w_ptr_p1  = (OW+1)'(r_ptr) + (OW+1)'(1);
    assign w_ptr_p2  = (OW+1)'(r_ptr) + (OW+1)'(2);
    assign w_occ_x   = (OW+1)'(r_occ);
    assign w_key     = '{obj: r_obj, blk: r_blk};
    // with the policy bit set reads go to the head; demotes always go to the tail
    assign w_at_head = r_policy && (r_act == ACT_READ);

    always_comb begin
        n_state     = r_state;
        n_ptr       = r_ptr;
        n_occ       = r_occ;
        n_left      = r_left;
        n_blk       = r_blk;
        n_hit       = r_hit;
        n_out_valid = 1'b0;
        n_out_kind  = r_out_kind;
        n_out_obj   = r_out_obj;
        n_out_blk   = r_out_blk;
        n_out_last  = r_out_last;
        w_rd_addr   = r_ptr;
        w_we        = 1'b0;
        w_wa        = r_ptr;
        w_wd        = r_rd_data;
        w_adv       = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_blk  = i_start_block;
                    n_left = w_cnt_sat;
                    if (w_cnt_sat != '0) begin
                        n_state = S_LOOK;
                    end
                end
            end
            S_LOOK: begin
                w_rd_addr = '0;
                n_ptr     = '0;
                n_hit     = 1'b0;
                if (r_occ == '0) begin
                    n_state = S_INS;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_rd_data == w_key) begin
                    // hit at r_ptr: close the gap behind it
                    n_hit = 1'b1;
                    if (w_ptr_p1 < w_occ_x) begin
                        w_rd_addr = w_ptr_p1[AW-1:0];
                        n_state   = S_SHDN;
                    end else begin
                        n_occ   = r_occ - OW'(1);
                        n_state = S_INS;
                    end
                end else if (w_ptr_p1 == w_occ_x) begin
                    if (r_occ == OW'(CAPACITY)) begin
                        // full: evict the head and shift everything down
                        w_rd_addr = AW'(1);
                        n_ptr     = '0;
                        n_state   = S_SHDN;
                        if (r_demote) begin
                            n_out_valid = 1'b1;
                            n_out_kind  = KIND_EVICT_DEM;
                            n_out_obj   = r_head.obj;
                            n_out_blk   = r_head.blk;
                            n_out_last  = 1'b0;
                        end
                    end else begin
                        n_state = S_INS;
                    end
                end else begin
                    n_ptr     = w_ptr_p1[AW-1:0];
                    w_rd_addr = w_ptr_p1[AW-1:0];
                end
            end
            S_SHDN: begin
                w_we = 1'b1;
                w_wa = r_ptr;
                w_wd = r_rd_data;
                if (w_ptr_p2 < w_occ_x) begin
                    w_rd_addr = w_ptr_p2[AW-1:0];
                    n_ptr     = w_ptr_p1[AW-1:0];
                end else begin
                    n_occ   = r_occ - OW'(1);
                    n_state = S_INS;
                end
            end
            S_INS: begin
                n_out_valid = 1'b1;
                n_out_obj   = r_obj;
                n_out_blk   = r_blk;
                n_out_last  = (r_left == CW'(1));
                if (r_hit) begin
                    n_out_kind = (r_act == ACT_DEMOTE) ? KIND_DEMOTE_HIT : KIND_READ_HIT;
                end else begin
                    n_out_kind = (r_act == ACT_DEMOTE) ? KIND_DEMOTE_MISS : KIND_READ_MISS;
                end
                if (!w_at_head) begin
                    w_we  = 1'b1;
                    w_wa  = AW'(r_occ);
                    w_wd  = w_key;
                    n_occ = r_occ + OW'(1);
                    w_adv = 1'b1;
                end else if (r_occ == '0) begin
                    w_we  = 1'b1;
                    w_wa  = '0;
                    w_wd  = w_key;
                    n_occ = r_occ + OW'(1);
                    w_adv = 1'b1;
                end else begin
                    // open a hole at the head, moving from the tail back
                    w_rd_addr = AW'(r_occ - OW'(1));
                    n_ptr     = AW'(r_occ - OW'(1));
                    n_state   = S_SHUP;
                end
            end
            S_SHUP: begin
                w_we = 1'b1;
                w_wa = w_ptr_p1[AW-1:0];
                w_wd = r_rd_data;
                if (r_ptr == '0) begin
                    n_state = S_HEADW;
                end else begin
                    w_rd_addr = r_ptr - AW'(1);
                    n_ptr     = r_ptr - AW'(1);
                end
            end
            S_HEADW: begin
                w_we  = 1'b1;
                w_wa  = '0;
                w_wd  = w_key;
                n_occ = r_occ + OW'(1);
                w_adv = 1'b1;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (w_adv) begin
            n_blk  = r_blk + 32'd1;
            n_left = r_left - CW'(1);
            n_state = (r_left == CW'(1)) ? S_IDLE : S_LOOK;
        end
    end

    // entry memory, registered read
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wa] <= w_wd;
        end
        r_rd_data <= r_mem[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_occ       <= '0;
            r_policy    <= 1'b0;
            r_demote    <= 1'b0;
            r_out_valid <= 1'b0;
            r_left      <= '0;
            r_hit       <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_occ       <= n_occ;
            r_out_valid <= n_out_valid;
            r_left      <= n_left;
            r_hit       <= n_hit;
            if (i_cfg_valid) begin
                if (i_cfg_index == CFG_EJECT_POLICY) begin
                    r_policy <= i_cfg_data;
                end else if (i_cfg_index == CFG_DEMOTE_ON_EVICT) begin
                    r_demote <= i_cfg_data;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr      <= n_ptr;
        r_blk      <= n_blk;
        r_out_kind <= n_out_kind;
        r_out_obj  <= n_out_obj;
        r_out_blk  <= n_out_blk;
        r_out_last <= n_out_last;
        r_out_org  <= r_org;
        if (r_state == S_IDLE && start) begin
            r_act <= i_action;
            r_org <= i_origin;
            r_obj <= i_object_id;
        end
        // keep the head word seen at the start of the scan for eviction
        if (r_state == S_SCAN && r_ptr == '0) begin
            r_head <= r_rd_data;
        end
    end

    assign o_result_valid = r_out_valid;
    assign o_kind         = r_out_kind;
    assign o_out_object   = r_out_obj;
    assign o_out_block    = r_out_blk;
    assign o_out_origin   = r_out_org;
    assign o_last         = r_out_last;

endmodule
